### hdl/lis_pkg.sv
`default_nettype none

package lis_pkg;

  // fixed field widths and the default store capacity
  localparam int unsigned DataW        = 32;
  localparam int unsigned LenW         = 7;
  localparam int unsigned MaxElemsDef  = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETTLE,
    ST_STORE,
    ST_WALK_INIT,
    ST_WALK_WR,
    ST_WALK_LD,
    ST_EMIT_PATH,
    ST_EMIT_VAL,
    ST_EMIT_OUT
  } lis_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;         // latch new element, restart scan
    logic drop;         // element beyond capacity
    logic scan_rd;      // read stored entry at scan pointer
    logic store;        // write the new entry
    logic walk_init;    // start back-walk from best end
    logic walk_step;    // record path entry, fetch predecessor
    logic walk_load;    // take fetched predecessor
    logic path_rd;      // read path entry for output
    logic val_emit_rd;  // read value of path entry
    logic emit;         // present one result
  } lis_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic in_final;
    logic walk_last;
    logic emit_last;
  } lis_status_t;

endpackage

`default_nettype wire

### hdl/lis_ctrl.sv
`default_nettype none

module lis_ctrl
  import lis_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire         is_final_i,
  input  lis_status_t status_i,
  output lis_cmd_t    cmd_o,
  output logic        busy_o
);

  lis_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (status_i.full) begin
            cmd_o.drop = 1'b1;
            state_d    = is_final_i ? ST_WALK_INIT : ST_IDLE;
          end else if (status_i.empty) begin
            state_d = ST_STORE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = status_i.in_final ? ST_WALK_INIT : ST_IDLE;
      end
      ST_WALK_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_d         = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        cmd_o.walk_step = 1'b1;
        state_d         = status_i.walk_last ? ST_EMIT_PATH : ST_WALK_LD;
      end
      ST_WALK_LD: begin
        cmd_o.walk_load = 1'b1;
        state_d         = ST_WALK_WR;
      end
      ST_EMIT_PATH: begin
        cmd_o.path_rd = 1'b1;
        state_d       = ST_EMIT_VAL;
      end
      ST_EMIT_VAL: begin
        cmd_o.val_emit_rd = 1'b1;
        state_d           = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = status_i.emit_last ? ST_IDLE : ST_EMIT_PATH;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/lis_dp.sv
`default_nettype none

module lis_dp
  import lis_pkg::*;
#(
  parameter int unsigned MaxElems = MaxElemsDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire signed [DataW-1:0]   elem_value_i,
  input  wire                      is_final_i,
  input  lis_cmd_t                 cmd_i,
  output lis_status_t              status_o,
  output logic                     out_strobe_o,
  output logic signed [DataW-1:0]  out_value_o,
  output logic [LenW-1:0]          subseq_length_o,
  output logic                     end_of_run_o,
  output logic                     overflow_o
);

  localparam int unsigned IW = $clog2(MaxElems);
  localparam int unsigned CW = $clog2(MaxElems + 1);

  // storage
  logic signed [DataW-1:0] val_mem  [MaxElems];
  logic [CW-1:0]           len_mem  [MaxElems];
  logic [IW-1:0]           pred_mem [MaxElems];
  logic [IW-1:0]           path_mem [MaxElems];

  logic signed [DataW-1:0] val_rd_q;
  logic [CW-1:0]           len_rd_q;
  logic [IW-1:0]           pred_rd_q;
  logic [IW-1:0]           path_rd_q;
  logic                    rd_vld_q;

  logic signed [DataW-1:0] in_value_q;
  logic                    in_final_q;
  logic [CW-1:0]           cnt_q;
  logic                    ovf_q;
  logic [CW-1:0]           ptr_q;
  logic [CW-1:0]           best_len_q;
  logic [IW-1:0]           best_pred_q;
  logic [CW-1:0]           max_len_q;
  logic [IW-1:0]           max_idx_q;
  logic [CW-1:0]           walk_k_q;
  logic [IW-1:0]           walk_idx_q;

  logic signed [DataW-1:0] out_value_q;
  logic [LenW-1:0]         out_len_q;
  logic                    out_end_q;
  logic                    out_ovf_q;
  logic                    out_strobe_q;

  logic [CW-1:0] len_inc;
  logic [CW-1:0] ptr_m1;
  logic [CW-1:0] ptr_p1;
  logic [CW-1:0] walk_km1;
  logic [IW-1:0] val_raddr;
  logic          take;

  assign len_inc   = len_rd_q + CW'(1);
  assign ptr_m1    = ptr_q - CW'(1);
  assign ptr_p1    = ptr_q + CW'(1);
  assign walk_km1  = walk_k_q - CW'(1);
  assign val_raddr = cmd_i.val_emit_rd ? path_rd_q : ptr_q[IW-1:0];

  // candidate predecessor: strictly smaller value and a strictly longer run
  assign take = rd_vld_q && (val_rd_q < in_value_q) && (len_inc > best_len_q);

  assign status_o.full      = (cnt_q == CW'(MaxElems));
  assign status_o.empty     = (cnt_q == '0);
  assign status_o.scan_last = (ptr_p1 == cnt_q);
  assign status_o.in_final  = in_final_q;
  assign status_o.walk_last = (walk_k_q == CW'(1));
  assign status_o.emit_last = (ptr_p1 == max_len_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      val_mem[cnt_q[IW-1:0]]  <= in_value_q;
      len_mem[cnt_q[IW-1:0]]  <= best_len_q;
      pred_mem[cnt_q[IW-1:0]] <= best_pred_q;
    end
    if (cmd_i.walk_step) begin
      path_mem[walk_km1[IW-1:0]] <= walk_idx_q;
    end
    val_rd_q  <= val_mem[val_raddr];
    len_rd_q  <= len_mem[ptr_q[IW-1:0]];
    pred_rd_q <= pred_mem[walk_idx_q];
    if (cmd_i.path_rd) begin
      path_rd_q <= path_mem[ptr_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_value_q <= elem_value_i;
    end
    if (cmd_i.emit) begin
      out_value_q <= val_rd_q;
      out_len_q   <= LenW'(max_len_q);
      out_end_q   <= status_o.emit_last;
      out_ovf_q   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_final_q   <= 1'b0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      ptr_q        <= '0;
      best_len_q   <= '0;
      best_pred_q  <= '0;
      max_len_q    <= '0;
      max_idx_q    <= '0;
      walk_k_q     <= '0;
      walk_idx_q   <= '0;
      rd_vld_q     <= 1'b0;
      out_strobe_q <= 1'b0;
    end else begin
      rd_vld_q     <= cmd_i.scan_rd;
      out_strobe_q <= cmd_i.emit;
      if (cmd_i.load) begin
        in_final_q  <= is_final_i;
        ptr_q       <= '0;
        best_len_q  <= CW'(1);
        best_pred_q <= '0;
      end
      if (cmd_i.drop) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.scan_rd) begin
        ptr_q <= ptr_p1;
      end
      if (take) begin
        best_len_q  <= len_inc;
        best_pred_q <= ptr_m1[IW-1:0];
      end
      if (cmd_i.store) begin
        cnt_q <= cnt_q + CW'(1);
        // earliest end with the greatest length
        if (status_o.empty || (best_len_q > max_len_q)) begin
          max_len_q <= best_len_q;
          max_idx_q <= cnt_q[IW-1:0];
        end
      end
      if (cmd_i.walk_init) begin
        walk_k_q   <= max_len_q;
        walk_idx_q <= max_idx_q;
        ptr_q      <= '0;
      end
      if (cmd_i.walk_step) begin
        walk_k_q <= walk_km1;
      end
      if (cmd_i.walk_load) begin
        walk_idx_q <= pred_rd_q;
      end
      if (cmd_i.emit) begin
        ptr_q <= ptr_p1;
        if (status_o.emit_last) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end
      end
    end
  end

  assign out_strobe_o    = out_strobe_q;
  assign out_value_o     = out_value_q;
  assign subseq_length_o = out_len_q;
  assign end_of_run_o    = out_end_q;
  assign overflow_o      = out_ovf_q;

endmodule

`default_nettype wire

### hdl/longest_increasing_subsequence_core.sv
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------------
// element  | in        | start_i & !busy_o    | elem_value_i, is_final_i
// result   | out       | out_strobe_o (1 cyc) | out_value_o, subseq_length_o,
//          |           |                      | end_of_run_o, overflow_o
//
// an element keeps the block busy while the single read port of the value and length
// memories is swept once over the stored entries, one entry per cycle, and then
// the new entry is written
// a dropped element (store full) leaves the block idle unless it is final
// a final element then starts a predecessor walk-back that fills the path memory, then
// outputs the run from it in order; each result shows on the ports for one cycle
// reset clears all control state; the memories need no clearing
// the receiver cannot stall, so results leave at a fixed pace

module longest_increasing_subsequence_core
  import lis_pkg::*;
#(
  parameter int unsigned MaxElems = MaxElemsDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // element transaction
  input  wire                      start_i,
  output logic                     busy_o,
  input  wire signed [DataW-1:0]   elem_value_i,
  input  wire                      is_final_i,
  // result transaction
  output logic                     out_strobe_o,
  output logic signed [DataW-1:0]  out_value_o,
  output logic [LenW-1:0]          subseq_length_o,
  output logic                     end_of_run_o,
  output logic                     overflow_o
);

  // command and status between sequencer and datapath
  lis_cmd_t    cmd;
  lis_status_t status;

  // sequencer: scan, store, walk-back and output phases
  lis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .is_final_i (is_final_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  // datapath: entry memories, run-length compare, path memory, output registers
  lis_dp #(
    .MaxElems (MaxElems)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .elem_value_i    (elem_value_i),
    .is_final_i      (is_final_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_strobe_o    (out_strobe_o),
    .out_value_o     (out_value_o),
    .subseq_length_o (subseq_length_o),
    .end_of_run_o    (end_of_run_o),
    .overflow_o      (overflow_o)
  );

endmodule

`default_nettype wire

### bench/longest_increasing_subsequence_checker.sv
`default_nettype none

module longest_increasing_subsequence_checker
  import lis_pkg::*;
#(
  parameter int unsigned MaxElems = MaxElemsDef
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire                     busy_o,
  input  wire signed [DataW-1:0]  elem_value_i,
  input  wire                     is_final_i,
  input  wire                     out_strobe_o,
  input  wire signed [DataW-1:0]  out_value_o,
  input  wire [LenW-1:0]          subseq_length_o,
  input  wire                     end_of_run_o,
  input  wire                     overflow_o,
  output int unsigned             mismatch_count_o,
  output int unsigned             results_waiting_o
);

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [LenW-1:0]         length;
    logic                    last;
    logic                    ovf;
  } subseq_elem_t;

  // predictor copy of the dp tables
  logic signed [DataW-1:0] seq_value [MaxElems];
  logic [LenW-1:0]         run_length [MaxElems];
  logic [LenW-1:0]         run_pred [MaxElems];
  int unsigned             seq_count = 0;
  bit                      seq_dropped = 1'b0;

  subseq_elem_t subseq_queue [$];
  int unsigned  fail_tally = 0;
  int unsigned  waiting = 0;

  assign mismatch_count_o  = fail_tally;
  assign results_waiting_o = waiting;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    fail_tally++;
  endtask

  // longest run ending at the new element, earliest predecessor on a tie
  function automatic void extend_runs(input logic signed [DataW-1:0] v);
    int unsigned best_len;
    int unsigned best_pred;
    best_len  = 1;
    best_pred = 0;
    for (int unsigned j = 0; j < seq_count; j++) begin
      if (seq_value[j] < v && run_length[j] + 1 > best_len) begin
        best_len  = run_length[j] + 1;
        best_pred = j;
      end
    end
    seq_value[seq_count]  = v;
    run_length[seq_count] = LenW'(best_len);
    run_pred[seq_count]   = LenW'(best_pred);
    seq_count++;
  endfunction

  // earliest end with the greatest length, walked back then queued in order
  function automatic void trace_subsequence();
    int unsigned best_len;
    int unsigned best_idx;
    int unsigned idx;
    int unsigned path [MaxElems];
    subseq_elem_t item;
    best_len = 0;
    best_idx = 0;
    for (int unsigned i = 0; i < seq_count; i++) begin
      if (run_length[i] > best_len) begin
        best_len = run_length[i];
        best_idx = i;
      end
    end
    idx = best_idx;
    for (int k = int'(best_len); k > 0; k--) begin
      path[k-1] = idx;
      if (k > 1) idx = run_pred[idx];
    end
    for (int unsigned k = 0; k < best_len; k++) begin
      item.value  = seq_value[path[k]];
      item.length = LenW'(best_len);
      item.last   = (k + 1 == best_len);
      item.ovf    = seq_dropped;
      subseq_queue.push_back(item);
    end
    seq_count   = 0;
    seq_dropped = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    subseq_elem_t want;
    if (rst_ni) begin
      if (out_strobe_o) begin
        if (subseq_queue.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", out_value_o));
        end else begin
          want = subseq_queue.pop_front();
          if (out_value_o !== want.value)
            report_mismatch($sformatf("out_value %0d, expected %0d", out_value_o, want.value));
          if (subseq_length_o !== want.length)
            report_mismatch($sformatf("subseq_length %0d, expected %0d",
                                      subseq_length_o, want.length));
          if (end_of_run_o !== want.last)
            report_mismatch($sformatf("end_of_run %b, expected %b", end_of_run_o, want.last));
          if (overflow_o !== want.ovf)
            report_mismatch($sformatf("overflow %b, expected %b", overflow_o, want.ovf));
        end
      end
      if (start_i && !busy_o) begin
        if (seq_count < MaxElems) extend_runs(elem_value_i);
        else seq_dropped = 1'b1;
        if (is_final_i) trace_subsequence();
      end
      waiting <= subseq_queue.size();
    end
  end

endmodule

`default_nettype wire

### bench/longest_increasing_subsequence_core_tb.sv
`default_nettype none

module longest_increasing_subsequence_core_tb;
  import lis_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ItemTarget    = 380;
  localparam logic signed [DataW-1:0] MinVal = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] MaxVal = 32'sh7fff_ffff;

  typedef enum int unsigned {
    VAL_WIDE,    // any 32-bit pattern
    VAL_NARROW,  // tight range, lots of equal values
    VAL_RAMP     // mostly rising, so runs get long
  } value_style_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic signed [DataW-1:0] elem_value_i;
  logic                    is_final_i;
  logic                    out_strobe_o;
  logic signed [DataW-1:0] out_value_o;
  logic [LenW-1:0]         subseq_length_o;
  logic                    end_of_run_o;
  logic                    overflow_o;

  int unsigned mismatch_count;
  int unsigned results_waiting;
  int unsigned idle_pct;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  longest_increasing_subsequence_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .elem_value_i    (elem_value_i),
    .is_final_i      (is_final_i),
    .out_strobe_o    (out_strobe_o),
    .out_value_o     (out_value_o),
    .subseq_length_o (subseq_length_o),
    .end_of_run_o    (end_of_run_o),
    .overflow_o      (overflow_o)
  );

  longest_increasing_subsequence_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .elem_value_i      (elem_value_i),
    .is_final_i        (is_final_i),
    .out_strobe_o      (out_strobe_o),
    .out_value_o       (out_value_o),
    .subseq_length_o   (subseq_length_o),
    .end_of_run_o      (end_of_run_o),
    .overflow_o        (overflow_o),
    .mismatch_count_o  (mismatch_count),
    .results_waiting_o (results_waiting)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // watchdog: any transaction on either side restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || out_strobe_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // next element of a sequence in the given style, now and then an extreme, zero or minus one
  function automatic logic signed [DataW-1:0] pick_value(input value_style_e style,
                                                         input logic signed [DataW-1:0] prev);
    if ($urandom_range(31) == 0) begin
      case ($urandom_range(3))
        0:       return MinVal;
        1:       return MaxVal;
        2:       return '0;
        default: return -1;
      endcase
    end
    case (style)
      VAL_WIDE:   return $urandom;
      VAL_NARROW: return $signed($urandom_range(16)) - 8;
      default: begin
        // occasional step back keeps the predecessor choice interesting
        if ($urandom_range(4) == 0) return prev - $signed($urandom_range(20));
        return prev + $signed($urandom_range(3));
      end
    endcase
  endfunction

  // one element transaction; idle cycles go in front of it, with junk payload
  task automatic send_elem(input logic signed [DataW-1:0] v, input logic last);
    int unsigned gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start_i      <= 1'b0;
      elem_value_i <= $urandom;
      is_final_i   <= $urandom_range(1);
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    elem_value_i <= v;
    is_final_i   <= last;
    @(posedge clk_i);
    // accepted at the first edge that sees busy low
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_sequence(input int unsigned len, input value_style_e style);
    logic signed [DataW-1:0] v;
    v = $signed($urandom_range(200)) - 100;
    for (int unsigned n = 1; n <= len; n++) begin
      v = pick_value(style, v);
      send_elem(v, n == len);
    end
  endtask

  initial begin
    value_style_e style;
    int unsigned  len;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    elem_value_i <= '0;
    is_final_i   <= 1'b0;
    idle_pct     = 19;
    items_sent   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a lone final element: run of one
    send_elem(MinVal, 1'b1);
    // equal values never extend a run
    send_elem(5, 1'b0);
    send_elem(5, 1'b0);
    send_elem(5, 1'b1);
    // rising across the full signed range, both extremes included
    send_elem(MinVal, 1'b0);
    send_elem(-1, 1'b0);
    send_elem(0, 1'b0);
    send_elem(1, 1'b0);
    send_elem(MaxVal, 1'b1);
    // two predecessors give the same length: the earlier one wins
    send_elem(2, 1'b0);
    send_elem(1, 1'b0);
    send_elem(3, 1'b1);
    // two ends with the same length: the earlier end wins
    send_elem(4, 1'b0);
    send_elem(5, 1'b0);
    send_elem(1, 1'b0);
    send_elem(2, 1'b1);
    // strictly falling: every run is one long
    send_elem(MaxVal, 1'b0);
    send_elem(0, 1'b0);
    send_elem(MinVal, 1'b1);

    // exactly full store, long runs, then overflow with the final dropped
    send_sequence(MaxElemsDef, VAL_RAMP);
    send_sequence(MaxElemsDef + 3, VAL_NARROW);

    // random sequences: mostly short, now and then around capacity
    while (items_sent < ItemTarget) begin
      if (items_sent >= 2 * ItemTarget / 3) idle_pct = 0;
      else if (items_sent >= ItemTarget / 3) idle_pct = 63;
      if ($urandom_range(11) == 0) len = $urandom_range(70, 60);
      else len = $urandom_range(16, 1);
      style = value_style_e'($urandom_range(2));
      send_sequence(len, style);
    end
    start_i <= 1'b0;

    // drain, then a short settle for anything stray
    @(posedge clk_i);
    while (results_waiting != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hdl/lis_pkg.sv
hdl/lis_ctrl.sv
hdl/lis_dp.sv
hdl/longest_increasing_subsequence_core.sv
bench/longest_increasing_subsequence_checker.sv
bench/longest_increasing_subsequence_core_tb.sv
